// ----- rtl/vcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// vcsd_pkg
// Shared types, action codes and control-code constants for the VDU control
// stream decoder.
// ----------------------------------------------------------------------------
package vcsd_pkg;

    localparam int unsigned MAX_PARAM_BYTES_DEF = 9;

    // Parameter bytes ever read by a command handler (glyph definition uses 9)
    localparam int unsigned PARAM_VIEW = 9;

    typedef enum logic [2:0] {
        ACT_WRITE_CHAR = 3'd0,
        ACT_SET_COLOUR = 3'd1,
        ACT_SET_MODE   = 3'd2,
        ACT_DEF_GLYPH  = 3'd3,
        ACT_SET_CURSOR = 3'd4
    } vcsd_act_t;

    localparam logic [4:0] CODE_BACKSPACE = 5'd8;
    localparam logic [4:0] CODE_LINEFEED  = 5'd10;
    localparam logic [4:0] CODE_CLS       = 5'd12;
    localparam logic [4:0] CODE_COLOUR    = 5'd17;
    localparam logic [4:0] CODE_MODE      = 5'd22;
    localparam logic [4:0] CODE_GLYPH     = 5'd23;
    localparam logic [4:0] CODE_HOME      = 5'd30;
    localparam logic [4:0] CODE_MOVE      = 5'd31;

    localparam logic [7:0] CHAR_CLS     = 8'd12;
    localparam logic [2:0] MODE_MONO    = 3'd2;
    localparam logic [7:0] MODE_LIMIT   = 8'd4;
    localparam logic [5:0] FG_RESET     = 6'd3;
    localparam logic [5:0] BG_RESET     = 6'd0;
    localparam logic [5:0] FG_AFTER_MODE = 6'd7;
    localparam logic [5:0] BG_AFTER_MODE = 6'd0;
    localparam logic [2:0] HIGH_CHAR_BASE = 3'b111;  // 224 in the top three bits

    // Parameter bytes needed by each control code
    localparam logic [3:0] PARAM_COUNT [32] = '{
        4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd2, 4'd5, 4'd0, 4'd0, 4'd1, 4'd9,
        4'd8, 4'd5, 4'd0, 4'd0, 4'd4, 4'd4, 4'd0, 4'd2
    };

    // One queued entry: the first record of a byte plus its record count.
    // A count of three marks a mode change; the trailing clear-screen record
    // takes the first one's colours and the colour-reset record uses constants.
    typedef struct packed {
        vcsd_act_t   action;
        logic [7:0]  char_code;
        logic [5:0]  fg_colour;
        logic [5:0]  bg_colour;
        logic [2:0]  screen_mode;
        logic        mono_white;
        logic [7:0]  glyph_code;
        logic [63:0] glyph_rows;
        logic [7:0]  cursor_col;
        logic [7:0]  cursor_row;
        logic [1:0]  nrec;
    } vcsd_rec_t;

endpackage

// ----- rtl/vcsd_parser.sv -----
// ----------------------------------------------------------------------------
// vcsd_parser
// Byte decoder: collects command parameters, tracks colours and builds one
// queue entry per byte that produces output.
// ----------------------------------------------------------------------------
module vcsd_parser
    import vcsd_pkg::*;
#(
    parameter int unsigned MAX_PARAM_BYTES = MAX_PARAM_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       push,
    output vcsd_rec_t  push_rec
);

    localparam int unsigned IDX_W = $clog2(MAX_PARAM_BYTES);

    logic [4:0] pending_reg,   pending_next;
    logic [3:0] expected_reg,  expected_next;
    logic [3:0] collected_reg, collected_next;
    logic [5:0] fg_reg,        fg_next;
    logic [5:0] bg_reg,        bg_next;
    logic [7:0] store_reg [MAX_PARAM_BYTES];

    logic [7:0] p [PARAM_VIEW];
    logic       fire;
    logic       collecting;
    logic [3:0] coll_inc;
    logic       disp_en;
    logic [4:0] disp_code;
    logic       emit;
    vcsd_rec_t  rec;

    // Parameter view: the byte arriving now stands in for its own slot
    always_comb
    begin
        for (int i = 0; i < PARAM_VIEW; i++)
        begin
            if (collecting && collected_reg == 4'(i))
                p[i] = data_byte;
            else
                p[i] = store_reg[i];
        end
    end

    always_comb
    begin
        fire           = in_valid & in_ready;
        collecting     = (expected_reg != 4'd0);
        coll_inc       = collected_reg + 4'd1;
        pending_next   = pending_reg;
        expected_next  = expected_reg;
        collected_next = collected_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        disp_en        = 1'b0;
        disp_code      = data_byte[4:0];
        emit           = 1'b0;
        rec            = '0;
        rec.action     = ACT_WRITE_CHAR;
        rec.nrec       = 2'd1;
        rec.fg_colour  = fg_reg;
        rec.bg_colour  = bg_reg;

        if (collecting)
        begin
            if (coll_inc >= expected_reg)
            begin
                expected_next  = 4'd0;
                collected_next = 4'd0;
                disp_en        = 1'b1;
                disp_code      = pending_reg;
            end
            else
            begin
                collected_next = coll_inc;
            end
        end
        else if (data_byte[7:5] == 3'd0)
        begin
            if (PARAM_COUNT[data_byte[4:0]] != 4'd0)
            begin
                pending_next   = data_byte[4:0];
                expected_next  = PARAM_COUNT[data_byte[4:0]];
                collected_next = 4'd0;
            end
            else
            begin
                disp_en = 1'b1;
            end
        end
        else
        begin
            emit = 1'b1;
            rec.char_code = data_byte[7] ? {HIGH_CHAR_BASE, data_byte[4:0]} : data_byte;
        end

        if (disp_en)
        begin
            unique case (disp_code)
                CODE_BACKSPACE, CODE_LINEFEED, CODE_CLS:
                begin
                    emit          = 1'b1;
                    rec.char_code = {3'd0, disp_code};
                end
                CODE_COLOUR:
                begin
                    emit = 1'b1;
                    rec.action = ACT_SET_COLOUR;
                    if (p[0][7])
                        bg_next = p[0][5:0];
                    else
                        fg_next = p[0][5:0];
                    rec.fg_colour = fg_next;
                    rec.bg_colour = bg_next;
                end
                CODE_MODE:
                begin
                    if (p[0] <= MODE_LIMIT)
                    begin
                        emit            = 1'b1;
                        rec.action      = ACT_SET_MODE;
                        rec.screen_mode = p[0][2:0];
                        rec.mono_white  = (p[0][2:0] == MODE_MONO);
                        rec.nrec        = 2'd3;
                        fg_next         = FG_AFTER_MODE;
                        bg_next         = BG_AFTER_MODE;
                    end
                end
                CODE_GLYPH:
                begin
                    if (p[0][7])
                    begin
                        emit           = 1'b1;
                        rec.action     = ACT_DEF_GLYPH;
                        rec.glyph_code = {HIGH_CHAR_BASE, p[0][4:0]};
                        rec.glyph_rows = {p[8], p[7], p[6], p[5], p[4], p[3], p[2], p[1]};
                    end
                end
                CODE_HOME:
                begin
                    emit       = 1'b1;
                    rec.action = ACT_SET_CURSOR;
                end
                CODE_MOVE:
                begin
                    emit           = 1'b1;
                    rec.action     = ACT_SET_CURSOR;
                    rec.cursor_col = p[0];
                    rec.cursor_row = p[1];
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        push     = fire & emit;
        push_rec = rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 5'd0;
            expected_reg  <= 4'd0;
            collected_reg <= 4'd0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
        end
        else if (fire)
        begin
            pending_reg   <= pending_next;
            expected_reg  <= expected_next;
            collected_reg <= collected_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
        end
    end

    // Drop bytes that fall beyond the store
    always_ff @(posedge clk)
    begin
        if (fire && collecting && 32'(collected_reg) < MAX_PARAM_BYTES)
            store_reg[collected_reg[IDX_W-1:0]] <= data_byte;
    end

endmodule

// ----- rtl/vcsd_out_queue.sv -----
// ----------------------------------------------------------------------------
// vcsd_out_queue
// Two-entry result queue; expands a mode-change entry into its three records.
// ----------------------------------------------------------------------------
module vcsd_out_queue
    import vcsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  vcsd_rec_t   push_rec,
    output logic        not_full,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [7:0]  char_code,
    output logic [5:0]  fg_colour,
    output logic [5:0]  bg_colour,
    output logic [2:0]  screen_mode,
    output logic        mono_white,
    output logic [7:0]  glyph_code,
    output logic [63:0] glyph_rows,
    output logic [7:0]  cursor_col,
    output logic [7:0]  cursor_row,
    output logic        last
);

    vcsd_rec_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic [1:0] sub_reg,    sub_next;

    vcsd_rec_t  head;
    vcsd_rec_t  cur;
    logic       out_fire;
    logic       pop;

    always_comb
    begin
        head = q_reg[rd_ptr_reg];
        cur  = head;
        unique case (sub_reg)
            2'd0:
            begin
                cur = head;
            end
            2'd1:
            begin
                cur           = '0;
                cur.action    = ACT_WRITE_CHAR;
                cur.char_code = CHAR_CLS;
                cur.fg_colour = head.fg_colour;
                cur.bg_colour = head.bg_colour;
            end
            default:
            begin
                cur           = '0;
                cur.action    = ACT_SET_COLOUR;
                cur.fg_colour = FG_AFTER_MODE;
                cur.bg_colour = BG_AFTER_MODE;
            end
        endcase

        out_valid = (count_reg != 2'd0);
        not_full  = (count_reg != 2'd2);
        last      = ((sub_reg + 2'd1) == head.nrec);
        out_fire  = out_valid & out_ready;
        pop       = out_fire & last;

        sub_next    = sub_reg;
        if (out_fire)
            sub_next = last ? 2'd0 : sub_reg + 2'd1;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};

        action      = cur.action;
        char_code   = cur.char_code;
        fg_colour   = cur.fg_colour;
        bg_colour   = cur.bg_colour;
        screen_mode = cur.screen_mode;
        mono_white  = cur.mono_white;
        glyph_code  = cur.glyph_code;
        glyph_rows  = cur.glyph_rows;
        cursor_col  = cur.cursor_col;
        cursor_row  = cur.cursor_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// ----- rtl/vdu_control_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// vdu_control_stream_decoder_unit
// A byte's first record is registered into the result queue as it is taken.
// Throughput: one byte per cycle while the 2-entry result queue has room;
// records drain one per cycle with out_ready high; a mode change gives three.
// Reset: asynchronous, clears parser state, colours to 3 on 0, empties queue.
// ----------------------------------------------------------------------------
module vdu_control_stream_decoder_unit
    import vcsd_pkg::*;
#(
    parameter int unsigned MAX_PARAM_BYTES = MAX_PARAM_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // byte stream in
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    // action records out
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [7:0]  char_code,
    output logic [5:0]  fg_colour,
    output logic [5:0]  bg_colour,
    output logic [2:0]  screen_mode,
    output logic        mono_white,
    output logic [7:0]  glyph_code,
    output logic [63:0] glyph_rows,
    output logic [7:0]  cursor_col,
    output logic [7:0]  cursor_row,
    output logic        last
);

    logic      push;
    vcsd_rec_t push_rec;
    logic      not_full;

    // Accept a byte whenever the result queue has a free entry; the queue
    // parts the input side from a stalled consumer.
    assign in_ready = not_full;

    // Decode the byte against the parameter collector and colour state,
    // building at most one queue entry per byte.
    vcsd_parser #(
        .MAX_PARAM_BYTES (MAX_PARAM_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .push      (push),
        .push_rec  (push_rec)
    );

    // Hold entries and unroll a mode change into set-mode, clear-screen and
    // colour-reset words.
    vcsd_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_rec    (push_rec),
        .not_full    (not_full),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .action      (action),
        .char_code   (char_code),
        .fg_colour   (fg_colour),
        .bg_colour   (bg_colour),
        .screen_mode (screen_mode),
        .mono_white  (mono_white),
        .glyph_code  (glyph_code),
        .glyph_rows  (glyph_rows),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .last        (last)
    );

    // An empty queue must always take a byte
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("queue empty but input stalled");

    // A taken set-mode word is followed by the clear-screen word
    a_mode_then_cls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && action == ACT_SET_MODE) |=>
        (out_valid && action == ACT_WRITE_CHAR && char_code == CHAR_CLS))
        else $error("mode change not followed by clear screen");

    // Only the mode-change sequence produces more than one word per byte
    a_multi_only_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (action == ACT_SET_MODE || action == ACT_WRITE_CHAR))
        else $error("unexpected multi-word sequence");

    // Mono flag only with mode 2
    a_mono_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mono_white) |-> (action == ACT_SET_MODE && screen_mode == MODE_MONO))
        else $error("mono flag outside mode 2");

endmodule
